### design/ecso_pkg.sv
package ecso_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_SOLVE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] KIND_FOUND  = 2'd0;
  localparam logic [1:0] KIND_NOTRIP = 2'd1;
  localparam logic [1:0] KIND_STREET = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // datapath operation for the current cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_WIPE,
    OP_ACCEPT,
    OP_ADD,
    OP_READ,
    OP_CHK,
    OP_INIT,
    OP_WGO,
    OP_SCAN,
    OP_TAKE,
    OP_POP,
    OP_POP2,
    OP_WCHK,
    OP_MX,
    OP_MLOOP,
    OP_MY,
    OP_MSCAN,
    OP_MNEXT,
    OP_EMIT
  } ecso_op_t;

  typedef struct packed {
    logic wipe_done;
    logic scan_end;
    logic walk_hit;
    logic map_hit;
    logic sel_v;
    logic sp_zero;
    logic pre_fail;
    logic walk_bad;
    logic m_more;
    logic out_busy;
  } ecso_stat_t;

endpackage

### design/euler_circuit_street_order_core.sv
// Euler round-trip finder over numbered streets.
// Input channel (in_valid / in_stall): one command word per transfer.
//   clear: wipes all state; add: loads one street; solve: walks the graph and
//   answers trip found (with length) or no round trip; read: returns the next
//   street of the held trip, or nothing left.
// Output channel (out_valid / out_stall): one result word for solve and read,
//   none for clear and add. The result sits in an output register; a new
//   command is taken while it waits, but the next result holds until it drains.
// Every walk step and every trip mapping step scans the street table at most once,
//   one entry per cycle through its single read port.
// Reset: a clearing pass empties the street table; in_stall is high until it
//   finishes. A clear command runs the same pass.
// One command is in work at a time; in_stall is high while it runs.
module euler_circuit_street_order_core #(
  parameter int MAX_JUNCTIONS = 64,
  parameter int MAX_STREETS   = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_junction_a,
  input  logic [5:0]  in_junction_b,
  input  logic [10:0] in_street_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [10:0] out_street_out,
  output logic [11:0] out_trip_length,
  output logic        out_last
);

  ecso_pkg::ecso_op_t   op;
  ecso_pkg::ecso_stat_t stat;

  // sequencer: picks the datapath operation each cycle
  ecso_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .stat       (stat),
    .in_stall   (in_stall),
    .op         (op)
  );

  // street table, walk stack, junction path, trip list and output register
  ecso_dp #(
    .MAX_JUNCTIONS (MAX_JUNCTIONS),
    .MAX_STREETS   (MAX_STREETS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_command       (in_command),
    .in_junction_a    (in_junction_a),
    .in_junction_b    (in_junction_b),
    .in_street_number (in_street_number),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_street_out   (out_street_out),
    .out_trip_length  (out_trip_length),
    .out_last         (out_last),
    .stat             (stat)
  );

endmodule

### design/ecso_ctrl.sv
module ecso_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_command,
  input  ecso_pkg::ecso_stat_t  stat,
  output logic                  in_stall,
  output ecso_pkg::ecso_op_t    op
);

  typedef enum logic [4:0] {
    S_WIPE, S_IDLE, S_ADD, S_READ, S_CHK, S_INIT, S_WGO, S_SCAN, S_TAKE,
    S_POP, S_POP2, S_WCHK, S_MX, S_MLOOP, S_MY, S_MSCAN, S_MNEXT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    op = ecso_pkg::OP_NONE;
    case (state_r)
      S_WIPE:  op = stat.wipe_done ? ecso_pkg::OP_NONE : ecso_pkg::OP_WIPE;
      S_IDLE:  op = in_valid ? ecso_pkg::OP_ACCEPT : ecso_pkg::OP_NONE;
      S_ADD:   op = ecso_pkg::OP_ADD;
      S_READ:  op = ecso_pkg::OP_READ;
      S_CHK:   op = ecso_pkg::OP_CHK;
      S_INIT:  op = ecso_pkg::OP_INIT;
      S_WGO:   op = ecso_pkg::OP_WGO;
      S_SCAN:  op = ecso_pkg::OP_SCAN;
      S_TAKE:  op = ecso_pkg::OP_TAKE;
      S_POP:   op = ecso_pkg::OP_POP;
      S_POP2:  op = ecso_pkg::OP_POP2;
      S_WCHK:  op = ecso_pkg::OP_WCHK;
      S_MX:    op = ecso_pkg::OP_MX;
      S_MLOOP: op = ecso_pkg::OP_MLOOP;
      S_MY:    op = ecso_pkg::OP_MY;
      S_MSCAN: op = ecso_pkg::OP_MSCAN;
      S_MNEXT: op = ecso_pkg::OP_MNEXT;
      S_EMIT:  op = ecso_pkg::OP_EMIT;
      default: op = ecso_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_WIPE: begin
        if (stat.wipe_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            ecso_pkg::CMD_CLEAR: state_nxt = S_WIPE;
            ecso_pkg::CMD_ADD:   state_nxt = S_ADD;
            ecso_pkg::CMD_SOLVE: state_nxt = S_CHK;
            ecso_pkg::CMD_READ:  state_nxt = S_READ;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD:  state_nxt = S_IDLE;
      S_READ: state_nxt = S_EMIT;
      S_CHK:  state_nxt = stat.pre_fail ? S_EMIT : S_INIT;
      S_INIT: begin
        if (stat.scan_end) state_nxt = S_WGO;
      end
      S_WGO:  state_nxt = stat.sp_zero ? S_WCHK : S_SCAN;
      S_SCAN: begin
        if (stat.walk_hit) state_nxt = S_TAKE;
        else if (stat.scan_end) state_nxt = stat.sel_v ? S_TAKE : S_POP;
      end
      S_TAKE:  state_nxt = S_WGO;
      S_POP:   state_nxt = S_POP2;
      S_POP2:  state_nxt = S_WGO;
      S_WCHK:  state_nxt = stat.walk_bad ? S_EMIT : S_MX;
      S_MX:    state_nxt = S_MLOOP;
      S_MLOOP: state_nxt = stat.m_more ? S_MY : S_EMIT;
      S_MY:    state_nxt = S_MSCAN;
      S_MSCAN: begin
        if (stat.map_hit || stat.scan_end) state_nxt = S_MNEXT;
      end
      S_MNEXT: state_nxt = S_MLOOP;
      S_EMIT: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/ecso_dp.sv
module ecso_dp #(
  parameter int MAX_JUNCTIONS = 64,
  parameter int MAX_STREETS   = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ecso_pkg::ecso_op_t    op,
  input  logic [1:0]            in_command,
  input  logic [5:0]            in_junction_a,
  input  logic [5:0]            in_junction_b,
  input  logic [10:0]           in_street_number,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [10:0]           out_street_out,
  output logic [11:0]           out_trip_length,
  output logic                  out_last,
  output ecso_pkg::ecso_stat_t  stat
);

  localparam int JW   = $clog2(MAX_JUNCTIONS);
  localparam int SW   = $clog2(MAX_STREETS);
  localparam int IW   = SW + 1;
  localparam int PD   = MAX_STREETS + 1;
  localparam int PAW  = $clog2(PD);
  localparam int PW   = $clog2(PD + 1);
  localparam int OW   = $clog2(MAX_JUNCTIONS + 1);
  localparam int WW   = 2 * JW + 3;
  localparam int B_LO = 2;
  localparam int A_LO = JW + 2;
  localparam int V_B  = 2 * JW + 2;
  localparam logic [IW-1:0] NS = IW'(MAX_STREETS);

  // street word: valid, end a, end b, remaining, used
  logic [WW-1:0] st_mem [MAX_STREETS];
  logic [JW-1:0] stk_mem [PD];
  logic [JW-1:0] path_mem [PD];
  logic [SW-1:0] trip_mem [MAX_STREETS];

  logic [WW-1:0]  st_q_r;
  logic [JW-1:0]  stk_q_r, path_q_r;
  logic [SW-1:0]  trip_q_r;

  logic           st_we, stk_we, path_we, trip_we;
  logic [SW-1:0]  st_wa, st_ra;
  logic [WW-1:0]  st_wd;
  logic [PAW-1:0] stk_wa, stk_ra, path_wa, path_ra;
  logic [JW-1:0]  stk_wd, path_wd;

  // control
  logic [IW-1:0]            i_r, i_nxt;
  logic                     dv_r, dv_nxt;
  logic                     sel_v_r, sel_v_nxt;
  logic [MAX_JUNCTIONS-1:0] odd_r, odd_nxt;
  logic [OW-1:0]            odd_cnt_r, odd_cnt_nxt;
  logic [IW-1:0]            nvalid_r, nvalid_nxt;
  logic [IW-1:0]            walked_r, walked_nxt;
  logic [JW-1:0]            start_r, start_nxt;
  logic                     first_r, first_nxt;
  logic [IW-1:0]            trip_cnt_r, trip_cnt_nxt;
  logic [IW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]            sp_r, sp_nxt;
  logic [PW-1:0]            plen_r, plen_nxt;
  logic [PW-1:0]            m_r, m_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // payload
  logic [SW-1:0] didx_r, didx_nxt;
  logic [SW-1:0] sel_idx_r, sel_idx_nxt;
  logic [WW-1:0] sel_w_r, sel_w_nxt;
  logic [5:0]    lat_a_r, lat_a_nxt, lat_b_r, lat_b_nxt;
  logic [10:0]   lat_z_r, lat_z_nxt;
  logic [JW-1:0] top_r, top_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [1:0]    pend_kind_r, pend_kind_nxt;
  logic [10:0]   pend_street_r, pend_street_nxt;
  logic [11:0]   pend_len_r, pend_len_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [10:0]   out_street_r, out_street_nxt;
  logic [11:0]   out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;

  // scan decode
  logic          w_valid, w_rem, w_used;
  logic [JW-1:0] w_a, w_b, w_other, sel_a, sel_b, ai, bi;
  logic          walk_match, walk_hit, walk_tw, map_hit, scan_end, add_ok;

  assign w_valid = st_q_r[V_B];
  assign w_rem   = st_q_r[1];
  assign w_used  = st_q_r[0];
  assign w_a     = st_q_r[A_LO +: JW];
  assign w_b     = st_q_r[B_LO +: JW];
  assign w_other = (w_a == top_r) ? w_b : w_a;
  assign sel_a   = sel_w_r[A_LO +: JW];
  assign sel_b   = sel_w_r[B_LO +: JW];

  assign walk_match = dv_r && w_valid && w_rem && ((w_a == top_r) || (w_b == top_r));
  assign walk_hit   = walk_match && (w_other != start_r);
  assign walk_tw    = walk_match && (w_other == start_r);
  assign map_hit    = dv_r && w_valid && !w_used &&
                      (((w_a == x_r) && (w_b == y_r)) || ((w_a == y_r) && (w_b == x_r)));
  assign scan_end   = (i_r == NS) && !dv_r;

  assign ai     = JW'(lat_a_r);
  assign bi     = JW'(lat_b_r);
  assign add_ok = (32'(lat_a_r) < MAX_JUNCTIONS) && (32'(lat_b_r) < MAX_JUNCTIONS) &&
                  (32'(lat_z_r) < MAX_STREETS) && !w_valid;

  always_comb begin
    stat.wipe_done = (i_r == NS);
    stat.scan_end  = scan_end;
    stat.walk_hit  = walk_hit;
    stat.map_hit   = map_hit;
    stat.sel_v     = sel_v_r;
    stat.sp_zero   = (sp_r == '0);
    stat.pre_fail  = !first_r || (odd_cnt_r != '0);
    stat.walk_bad  = (walked_r != nvalid_r);
    stat.m_more    = (m_r > PW'(1));
    stat.out_busy  = out_valid_r && out_stall;
  end

  always_comb begin
    i_nxt = i_r;  dv_nxt = dv_r;  sel_v_nxt = sel_v_r;
    odd_nxt = odd_r;  odd_cnt_nxt = odd_cnt_r;  nvalid_nxt = nvalid_r;
    walked_nxt = walked_r;  start_nxt = start_r;  first_nxt = first_r;
    trip_cnt_nxt = trip_cnt_r;  rd_ptr_nxt = rd_ptr_r;
    sp_nxt = sp_r;  plen_nxt = plen_r;  m_nxt = m_r;
    out_valid_nxt = out_valid_r;
    didx_nxt = didx_r;  sel_idx_nxt = sel_idx_r;  sel_w_nxt = sel_w_r;
    lat_a_nxt = lat_a_r;  lat_b_nxt = lat_b_r;  lat_z_nxt = lat_z_r;
    top_nxt = top_r;  x_nxt = x_r;  y_nxt = y_r;
    pend_kind_nxt = pend_kind_r;  pend_street_nxt = pend_street_r;
    pend_len_nxt = pend_len_r;  pend_last_nxt = pend_last_r;
    out_kind_nxt = out_kind_r;  out_street_nxt = out_street_r;
    out_len_nxt = out_len_r;  out_last_nxt = out_last_r;
    st_we = 1'b0;  st_wa = i_r[SW-1:0];  st_wd = '0;  st_ra = i_r[SW-1:0];
    stk_we = 1'b0;  stk_wa = PAW'(sp_r - PW'(1));  stk_wd = top_r;
    stk_ra = PAW'(sp_r - PW'(2));
    path_we = 1'b0;  path_wa = PAW'(plen_r);  path_wd = top_r;
    path_ra = PAW'(m_r - PW'(2));
    trip_we = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    // scans issue one read a cycle; data comes back the next cycle
    if (op == ecso_pkg::OP_INIT || op == ecso_pkg::OP_SCAN || op == ecso_pkg::OP_MSCAN) begin
      if (i_r < NS) begin
        i_nxt    = i_r + IW'(1);
        dv_nxt   = 1'b1;
        didx_nxt = i_r[SW-1:0];
      end else begin
        dv_nxt = 1'b0;
      end
    end

    case (op)
      ecso_pkg::OP_WIPE: begin
        st_we = 1'b1;
        i_nxt = i_r + IW'(1);
      end
      ecso_pkg::OP_ACCEPT: begin
        lat_a_nxt = in_junction_a;
        lat_b_nxt = in_junction_b;
        lat_z_nxt = in_street_number;
        st_ra     = SW'(in_street_number);
        if (in_command == ecso_pkg::CMD_CLEAR) begin
          i_nxt = '0;  odd_nxt = '0;  odd_cnt_nxt = '0;  nvalid_nxt = '0;
          start_nxt = '0;  first_nxt = 1'b0;  trip_cnt_nxt = '0;  rd_ptr_nxt = '0;
        end
      end
      ecso_pkg::OP_ADD: begin
        trip_cnt_nxt = '0;
        rd_ptr_nxt   = '0;
        if (add_ok) begin
          st_we = 1'b1;
          st_wa = SW'(lat_z_r);
          st_wd = {1'b1, ai, bi, 2'b00};
          odd_nxt[ai] = ~odd_nxt[ai];
          odd_nxt[bi] = ~odd_nxt[bi];
          if (ai != bi) begin
            if (!odd_r[ai] && !odd_r[bi]) odd_cnt_nxt = odd_cnt_r + OW'(2);
            else if (odd_r[ai] && odd_r[bi]) odd_cnt_nxt = odd_cnt_r - OW'(2);
          end
          nvalid_nxt = nvalid_r + IW'(1);
          if (!first_r) begin
            start_nxt = (ai < bi) ? ai : bi;
            first_nxt = 1'b1;
          end
        end
      end
      ecso_pkg::OP_READ: begin
        if (rd_ptr_r < trip_cnt_r) begin
          pend_kind_nxt   = ecso_pkg::KIND_STREET;
          pend_street_nxt = 11'(trip_q_r);
          pend_last_nxt   = ((rd_ptr_r + IW'(1)) == trip_cnt_r);
          rd_ptr_nxt      = rd_ptr_r + IW'(1);
        end else begin
          pend_kind_nxt   = ecso_pkg::KIND_NONE;
          pend_street_nxt = '0;
          pend_last_nxt   = 1'b0;
        end
        pend_len_nxt = '0;
      end
      ecso_pkg::OP_CHK: begin
        trip_cnt_nxt = '0;  rd_ptr_nxt = '0;
        pend_kind_nxt = ecso_pkg::KIND_NOTRIP;
        pend_street_nxt = '0;  pend_len_nxt = '0;  pend_last_nxt = 1'b0;
        i_nxt = '0;  dv_nxt = 1'b0;
        sp_nxt = PW'(1);  top_nxt = start_r;  plen_nxt = '0;  walked_nxt = '0;
      end
      ecso_pkg::OP_INIT: begin
        if (dv_r) begin
          st_we = 1'b1;
          st_wa = didx_r;
          st_wd = {w_valid, w_a, w_b, w_valid, 1'b0};
        end
      end
      ecso_pkg::OP_WGO: begin
        i_nxt = '0;  dv_nxt = 1'b0;  sel_v_nxt = 1'b0;
      end
      ecso_pkg::OP_SCAN: begin
        if (walk_hit || walk_tw) begin
          sel_v_nxt   = 1'b1;
          sel_idx_nxt = didx_r;
          sel_w_nxt   = st_q_r;
        end
      end
      ecso_pkg::OP_TAKE: begin
        st_we = 1'b1;
        st_wa = sel_idx_r;
        st_wd = {sel_w_r[WW-1:2], 1'b0, sel_w_r[0]};
        stk_we = 1'b1;
        top_nxt = (sel_a == top_r) ? sel_b : sel_a;
        sp_nxt = sp_r + PW'(1);
        walked_nxt = walked_r + IW'(1);
      end
      ecso_pkg::OP_POP: begin
        path_we  = 1'b1;
        plen_nxt = plen_r + PW'(1);
        sp_nxt   = sp_r - PW'(1);
      end
      ecso_pkg::OP_POP2: begin
        if (sp_r != '0) top_nxt = stk_q_r;
      end
      ecso_pkg::OP_WCHK: begin
        path_ra = PAW'(plen_r - PW'(1));
        m_nxt   = plen_r;
      end
      ecso_pkg::OP_MX: x_nxt = path_q_r;
      ecso_pkg::OP_MLOOP: begin
        pend_kind_nxt = ecso_pkg::KIND_FOUND;
        pend_len_nxt  = 12'(trip_cnt_r);
      end
      ecso_pkg::OP_MY: begin
        y_nxt = path_q_r;  i_nxt = '0;  dv_nxt = 1'b0;
      end
      ecso_pkg::OP_MSCAN: begin
        if (map_hit) begin
          st_we = 1'b1;
          st_wa = didx_r;
          st_wd = {st_q_r[WW-1:1], 1'b1};
          trip_we = 1'b1;
          trip_cnt_nxt = trip_cnt_r + IW'(1);
        end
      end
      ecso_pkg::OP_MNEXT: begin
        x_nxt = y_r;
        m_nxt = m_r - PW'(1);
      end
      ecso_pkg::OP_EMIT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pend_kind_r;
          out_street_nxt = pend_street_r;
          out_len_nxt    = pend_len_r;
          out_last_nxt   = pend_last_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_q_r <= st_mem[st_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q_r <= stk_mem[stk_ra];
    if (path_we) path_mem[path_wa] <= path_wd;
    path_q_r <= path_mem[path_ra];
    if (trip_we) trip_mem[trip_cnt_r[SW-1:0]] <= didx_r;
    trip_q_r <= trip_mem[rd_ptr_r[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;  dv_r <= 1'b0;  sel_v_r <= 1'b0;
      odd_r <= '0;  odd_cnt_r <= '0;  nvalid_r <= '0;  walked_r <= '0;
      start_r <= '0;  first_r <= 1'b0;  trip_cnt_r <= '0;  rd_ptr_r <= '0;
      sp_r <= '0;  plen_r <= '0;  m_r <= '0;  out_valid_r <= 1'b0;
    end else begin
      i_r <= i_nxt;  dv_r <= dv_nxt;  sel_v_r <= sel_v_nxt;
      odd_r <= odd_nxt;  odd_cnt_r <= odd_cnt_nxt;  nvalid_r <= nvalid_nxt;
      walked_r <= walked_nxt;  start_r <= start_nxt;  first_r <= first_nxt;
      trip_cnt_r <= trip_cnt_nxt;  rd_ptr_r <= rd_ptr_nxt;
      sp_r <= sp_nxt;  plen_r <= plen_nxt;  m_r <= m_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= didx_nxt;  sel_idx_r <= sel_idx_nxt;  sel_w_r <= sel_w_nxt;
    lat_a_r <= lat_a_nxt;  lat_b_r <= lat_b_nxt;  lat_z_r <= lat_z_nxt;
    top_r <= top_nxt;  x_r <= x_nxt;  y_r <= y_nxt;
    pend_kind_r <= pend_kind_nxt;  pend_street_r <= pend_street_nxt;
    pend_len_r <= pend_len_nxt;  pend_last_r <= pend_last_nxt;
    out_kind_r <= out_kind_nxt;  out_street_r <= out_street_nxt;
    out_len_r <= out_len_nxt;  out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_street_out  = out_street_r;
  assign out_trip_length = out_len_r;
  assign out_last        = out_last_r;

endmodule
